>>> hw/rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Opcodes, status codes and the command/status bundles shared by the
// stack machine controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

    localparam int KIND_W   = 5;
    localparam int WORD_W   = 32;
    localparam int ICHAR_W  = 9;
    localparam int OCHAR_W  = 8;
    localparam int STATUS_W = 3;

    // Opcodes
    localparam logic [KIND_W-1:0] OP_PUSH     = 5'd0;
    localparam logic [KIND_W-1:0] OP_POP      = 5'd1;
    localparam logic [KIND_W-1:0] OP_DUP      = 5'd2;
    localparam logic [KIND_W-1:0] OP_STORE    = 5'd3;
    localparam logic [KIND_W-1:0] OP_RETRIEVE = 5'd4;
    localparam logic [KIND_W-1:0] OP_ADD      = 5'd5;
    localparam logic [KIND_W-1:0] OP_SUB      = 5'd6;
    localparam logic [KIND_W-1:0] OP_MUL      = 5'd7;
    localparam logic [KIND_W-1:0] OP_DIV      = 5'd8;
    localparam logic [KIND_W-1:0] OP_MOD      = 5'd9;
    localparam logic [KIND_W-1:0] OP_JMP      = 5'd10;
    localparam logic [KIND_W-1:0] OP_JZ       = 5'd11;
    localparam logic [KIND_W-1:0] OP_JN       = 5'd12;
    localparam logic [KIND_W-1:0] OP_OUTCHAR  = 5'd13;
    localparam logic [KIND_W-1:0] OP_READCHAR = 5'd14;
    localparam logic [KIND_W-1:0] OP_HALT     = 5'd15;
    localparam logic [KIND_W-1:0] OP_EXIT     = 5'd16;
    localparam logic [KIND_W-1:0] OP_DISCARD  = 5'd17;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ADDR  = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic latch;     // capture item, read top two stack words
        logic exec;      // evaluate item, commit unless it must wait
        logic heap_fin;  // write retrieved heap word to top of stack
        logic div_fin;   // write quotient or remainder to stack
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic wait_heap; // retrieve needs a heap read
        logic wait_div;  // div or mod needs the divider
        logic div_done;  // divider result ready
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/sme_div.sv
// ----------------------------------------------------------------------------
// sme_div
// Signed 32-bit divider, truncating toward zero. Restoring, one quotient
// bit per cycle; done pulses as the last step is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [sme_pkg::WORD_W-1:0]  lhs,
    input  wire logic [sme_pkg::WORD_W-1:0]  rhs,
    output logic                             done,
    output logic [sme_pkg::WORD_W-1:0]       quot,
    output logic [sme_pkg::WORD_W-1:0]       rem
);

    localparam int W  = sme_pkg::WORD_W;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic          qneg_reg, qneg_next;
    logic          rneg_reg, rneg_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    // One restoring step
    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = lhs[W-1] ? (~lhs + 1'b1) : lhs;
            den_next  = rhs[W-1] ? (~rhs + 1'b1) : rhs;
            qneg_next = lhs[W-1] ^ rhs[W-1];
            rneg_next = lhs[W-1];
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    // Restore signs
    assign done = done_reg;
    assign quot = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rem  = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sme_dp.sv
// ----------------------------------------------------------------------------
// sme_dp
// Datapath: item registers, stack memory, heap memory, ALU, divider and
// result registers. Acts on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_dp #(
    parameter int STACK_DEPTH = 256,
    parameter int HEAP_DEPTH  = 4096
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire sme_pkg::dp_cmd_t                     cmd,
    output sme_pkg::dp_stat_t                         stat,
    input  wire logic [sme_pkg::KIND_W-1:0]           in_kind,
    input  wire logic signed [sme_pkg::WORD_W-1:0]    in_immediate,
    input  wire logic signed [sme_pkg::ICHAR_W-1:0]   in_input_char,
    output logic                                      out_char_valid,
    output logic [sme_pkg::OCHAR_W-1:0]               out_char,
    output logic                                      out_branch_taken,
    output logic signed [sme_pkg::WORD_W-1:0]         out_branch_label,
    output logic                                      out_halted,
    output logic [sme_pkg::STATUS_W-1:0]              out_status
);

    localparam int W  = sme_pkg::WORD_W;
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int SC = $clog2(STACK_DEPTH + 1);
    localparam int HA = $clog2(HEAP_DEPTH);

    // Item and state registers
    logic [sme_pkg::KIND_W-1:0]  kind_reg;
    logic [W-1:0]                imm_reg;
    logic [sme_pkg::ICHAR_W-1:0] ich_reg;
    logic [SC-1:0]               cnt_reg, cnt_next;
    logic                        exited_reg, exited_next;

    // Memories
    logic [W-1:0] stack_mem [STACK_DEPTH];
    logic [W-1:0] heap_mem  [HEAP_DEPTH];
    logic [W-1:0] tos_reg, nos_reg, heap_rd_reg;

    // Execute decisions
    logic                          st_we, hp_we, commit;
    logic [SA-1:0]                 st_wa;
    logic [W-1:0]                  st_wd, hp_wd;
    logic [HA-1:0]                 hp_wa;
    logic                          wait_heap, wait_div;
    logic [sme_pkg::STATUS_W-1:0]  status_c;
    logic                          cvalid_c, btaken_c;
    logic [sme_pkg::OCHAR_W-1:0]   cval_c;
    logic [W-1:0]                  blabel_c;
    logic                          tos_ok, nos_ok;
    logic                          has1, has2, full;

    // Divider
    logic          div_done;
    logic [W-1:0]  div_q, div_r;

    sme_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.exec && wait_div),
        .lhs     (nos_reg),
        .rhs     (tos_reg),
        .done    (div_done),
        .quot    (div_q),
        .rem     (div_r)
    );

    assign tos_ok = !tos_reg[W-1] && (tos_reg < W'(HEAP_DEPTH));
    assign nos_ok = !nos_reg[W-1] && (nos_reg < W'(HEAP_DEPTH));
    assign has1   = cnt_reg >= SC'(1);
    assign has2   = cnt_reg >= SC'(2);
    assign full   = cnt_reg >= SC'(STACK_DEPTH);

    // Decode and evaluate the held item
    always_comb begin
        st_we       = 1'b0;
        st_wa       = cnt_reg[SA-1:0];
        st_wd       = imm_reg;
        hp_we       = 1'b0;
        hp_wa       = tos_reg[HA-1:0];
        hp_wd       = tos_reg;
        wait_heap   = 1'b0;
        wait_div    = 1'b0;
        status_c    = sme_pkg::ST_OK;
        cvalid_c    = 1'b0;
        cval_c      = '0;
        btaken_c    = 1'b0;
        blabel_c    = '0;
        cnt_next    = cnt_reg;
        exited_next = exited_reg;
        commit      = 1'b0;

        if (cmd.exec && !exited_reg) begin
            case (kind_reg)
                sme_pkg::OP_PUSH: begin
                    if (full) status_c = sme_pkg::ST_OVER;
                    else begin
                        st_we    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                sme_pkg::OP_POP, sme_pkg::OP_DISCARD: begin
                    if (!has1) status_c = sme_pkg::ST_UNDER;
                    else cnt_next = cnt_reg - 1'b1;
                end
                sme_pkg::OP_DUP: begin
                    if (!has1) status_c = sme_pkg::ST_UNDER;
                    else if (full) status_c = sme_pkg::ST_OVER;
                    else begin
                        st_we    = 1'b1;
                        st_wd    = tos_reg;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                sme_pkg::OP_STORE: begin
                    if (!has2) status_c = sme_pkg::ST_UNDER;
                    else if (!nos_ok) status_c = sme_pkg::ST_ADDR;
                    else begin
                        hp_we    = 1'b1;
                        hp_wa    = nos_reg[HA-1:0];
                        cnt_next = cnt_reg - SC'(2);
                    end
                end
                sme_pkg::OP_RETRIEVE: begin
                    if (!has1) status_c = sme_pkg::ST_UNDER;
                    else if (!tos_ok) status_c = sme_pkg::ST_ADDR;
                    else wait_heap = 1'b1;
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL: begin
                    if (!has2) status_c = sme_pkg::ST_UNDER;
                    else begin
                        st_we    = 1'b1;
                        st_wa    = SA'(cnt_reg - SC'(2));
                        cnt_next = cnt_reg - 1'b1;
                        if (kind_reg == sme_pkg::OP_ADD) st_wd = nos_reg + tos_reg;
                        else if (kind_reg == sme_pkg::OP_SUB) st_wd = nos_reg - tos_reg;
                        else st_wd = W'(nos_reg * tos_reg);
                    end
                end
                sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
                    if (!has2) status_c = sme_pkg::ST_UNDER;
                    else if (tos_reg == '0) status_c = sme_pkg::ST_DIVZ;
                    else wait_div = 1'b1;
                end
                sme_pkg::OP_JMP: begin
                    btaken_c = 1'b1;
                    blabel_c = imm_reg;
                end
                sme_pkg::OP_JZ, sme_pkg::OP_JN: begin
                    if (!has1) status_c = sme_pkg::ST_UNDER;
                    else begin
                        cnt_next = cnt_reg - 1'b1;
                        if ((kind_reg == sme_pkg::OP_JZ && tos_reg == '0) ||
                            (kind_reg == sme_pkg::OP_JN && tos_reg[W-1])) begin
                            btaken_c = 1'b1;
                            blabel_c = imm_reg;
                        end
                    end
                end
                sme_pkg::OP_OUTCHAR: begin
                    if (!has1) status_c = sme_pkg::ST_UNDER;
                    else begin
                        cvalid_c = 1'b1;
                        cval_c   = tos_reg[sme_pkg::OCHAR_W-1:0];
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                sme_pkg::OP_READCHAR: begin
                    if (!has1) status_c = sme_pkg::ST_UNDER;
                    else if (!tos_ok) status_c = sme_pkg::ST_ADDR;
                    else begin
                        hp_we    = 1'b1;
                        hp_wd    = W'(signed'(ich_reg));
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                sme_pkg::OP_EXIT: exited_next = 1'b1;
                default: ;
            endcase
            commit = !wait_heap && !wait_div;
        end else if (cmd.exec) begin
            commit = 1'b1;
        end else if (cmd.heap_fin) begin
            st_we  = 1'b1;
            st_wa  = SA'(cnt_reg - 1'b1);
            st_wd  = heap_rd_reg;
            commit = 1'b1;
        end else if (cmd.div_fin) begin
            st_we    = 1'b1;
            st_wa    = SA'(cnt_reg - SC'(2));
            st_wd    = (kind_reg == sme_pkg::OP_DIV) ? div_q : div_r;
            cnt_next = cnt_reg - 1'b1;
            commit   = 1'b1;
        end
    end

    // Hold item, stack count and exit flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            exited_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            exited_reg <= exited_next;
        end
        if (cmd.latch) begin
            kind_reg <= in_kind;
            imm_reg  <= in_immediate;
            ich_reg  <= in_input_char;
        end
    end

    // Stack memory: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (st_we) stack_mem[st_wa] <= st_wd;
        if (cmd.latch) begin
            tos_reg <= stack_mem[SA'(cnt_reg - 1'b1)];
            nos_reg <= stack_mem[SA'(cnt_reg - SC'(2))];
        end
    end

    // Heap memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (hp_we) heap_mem[hp_wa] <= hp_wd;
        if (cmd.exec) heap_rd_reg <= heap_mem[tos_reg[HA-1:0]];
    end

    // Result registers
    always_ff @(posedge aclk) begin
        if (commit) begin
            out_char_valid   <= cvalid_c;
            out_char         <= cval_c;
            out_branch_taken <= btaken_c;
            out_branch_label <= blabel_c;
            out_halted       <= exited_next;
            out_status       <= status_c;
        end
    end

    assign stat.wait_heap = wait_heap;
    assign stat.wait_div  = wait_div;
    assign stat.div_done  = div_done;

endmodule

`default_nettype wire

>>> hw/rtl/sme_ctrl.sv
// ----------------------------------------------------------------------------
// sme_ctrl
// Controller: sequences one instruction at a time through latch, execute
// and optional heap or divide wait, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sme_pkg::dp_cmd_t        cmd,
    input  wire sme_pkg::dp_stat_t  stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HEAP,
        S_DIV
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Commands and next state
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready   = !m_valid_reg || m_ready;
                cmd.latch = s_valid && s_ready;
                if (cmd.latch) state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.wait_heap) state_next = S_HEAP;
                else if (stat.wait_div) state_next = S_DIV;
                else begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_HEAP: begin
                cmd.heap_fin = 1'b1;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.div_fin  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/stack_machine_execute.sv
// ----------------------------------------------------------------------------
// stack_machine_execute
// Executes one stack machine instruction per beat: operand stack, word heap,
// arithmetic, branch reporting and character I/O.
//
//   Channel  Ports                                         Direction
//   s_       kind, immediate, input_char                   in  (valid/ready)
//   m_       char_valid, out_char, branch_taken,
//            branch_label, halted, status                  out (valid/ready)
//
// Most instructions go from accept to result through latch (with stack
// read) and execute. Retrieve adds a heap memory read. Div and mod wait
// on the shared divider, which resolves one quotient bit per cycle.
// Reset clears the stack count, exit flag, controller and result valid;
// stack and heap contents are undefined until written.
// A new beat is accepted once the previous result is taken or is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_execute #(
    parameter int STACK_DEPTH = 256,
    parameter int HEAP_DEPTH  = 4096
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [sme_pkg::KIND_W-1:0]          s_kind,
    input  wire logic signed [sme_pkg::WORD_W-1:0]   s_immediate,
    input  wire logic signed [sme_pkg::ICHAR_W-1:0]  s_input_char,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_char_valid,
    output logic [sme_pkg::OCHAR_W-1:0]              m_out_char,
    output logic                                     m_branch_taken,
    output logic signed [sme_pkg::WORD_W-1:0]        m_branch_label,
    output logic                                     m_halted,
    output logic [sme_pkg::STATUS_W-1:0]             m_status
);

    sme_pkg::dp_cmd_t  cmd;
    sme_pkg::dp_stat_t stat;

    sme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    sme_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .HEAP_DEPTH  (HEAP_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_kind          (s_kind),
        .in_immediate     (s_immediate),
        .in_input_char    (s_input_char),
        .out_char_valid   (m_char_valid),
        .out_char         (m_out_char),
        .out_branch_taken (m_branch_taken),
        .out_branch_label (m_branch_label),
        .out_halted       (m_halted),
        .out_status       (m_status)
    );

`ifndef SYNTH
    // One instruction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a beat while another is executing");

    // Accept only when the result register is free or draining
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid || m_ready))
        else $error("accepted a beat over an untaken result");

    // Commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.latch, cmd.exec, cmd.heap_fin, cmd.div_fin}))
        else $error("controller issued conflicting commands");

    // Status code stays within the defined set
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= sme_pkg::ST_ADDR))
        else $error("undefined status code on result");
`endif

endmodule

`default_nettype wire

>>> dv/tb_stack_machine_execute.sv
// ----------------------------------------------------------------------------
// tb_stack_machine_execute
// Self-checking bench for the stack machine execute stage. A scoreboard keeps
// its own copy of the operand stack, the heap and the exit flag. It predicts
// one result per accepted instruction and checks each result beat in order.
// The bench runs a directed opening, a deep stack fill to reach overflow,
// random instruction streams with random idling on both channels and one
// long receiver stall, and finishes with exit and a few ignored beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stack_machine_execute;

    localparam int STK_N  = 256;
    localparam int HEAP_N = 4096;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  out_char;
        logic        branch_taken;
        logic [31:0] branch_label;
        logic        halted;
        logic [2:0]  status;
    } exec_result_t;

    // Instruction-level model of the machine plus the queue of expected beats
    class sme_scoreboard;
        logic [31:0]  stk [STK_N];
        int unsigned  depth;
        logic [31:0]  heap [HEAP_N];
        bit           heap_set [HEAP_N];
        bit           exited;
        exec_result_t pending [$];
        int           errors;

        function logic [31:0] top_word(int unsigned n);
            return stk[depth - 1 - n];
        endfunction

        function bit addr_ok(logic [31:0] a);
            return !a[31] && (a < HEAP_N);
        endfunction

        // Execute one accepted instruction and queue its result
        function void note_input(logic [4:0] k, logic [31:0] imm, logic [8:0] ich);
            exec_result_t r;
            logic signed [31:0] lhs, rhs;
            logic [31:0] res;
            r = '0;
            if (exited) begin
                r.halted = 1'b1;
                pending.insert(pending.size(), r);
                return;
            end
            case (k)
                sme_pkg::OP_PUSH: begin
                    if (depth >= STK_N) r.status = sme_pkg::ST_OVER;
                    else begin
                        stk[depth] = imm;
                        depth++;
                    end
                end
                sme_pkg::OP_POP, sme_pkg::OP_DISCARD: begin
                    if (depth < 1) r.status = sme_pkg::ST_UNDER;
                    else depth--;
                end
                sme_pkg::OP_DUP: begin
                    if (depth < 1) r.status = sme_pkg::ST_UNDER;
                    else if (depth >= STK_N) r.status = sme_pkg::ST_OVER;
                    else begin
                        stk[depth] = top_word(0);
                        depth++;
                    end
                end
                sme_pkg::OP_STORE: begin
                    if (depth < 2) r.status = sme_pkg::ST_UNDER;
                    else if (!addr_ok(top_word(1))) r.status = sme_pkg::ST_ADDR;
                    else begin
                        heap[top_word(1)] = top_word(0);
                        heap_set[top_word(1)] = 1'b1;
                        depth -= 2;
                    end
                end
                sme_pkg::OP_RETRIEVE: begin
                    if (depth < 1) r.status = sme_pkg::ST_UNDER;
                    else if (!addr_ok(top_word(0))) r.status = sme_pkg::ST_ADDR;
                    else stk[depth-1] = heap[top_word(0)];
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
                sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
                    if (depth < 2) r.status = sme_pkg::ST_UNDER;
                    else begin
                        rhs = top_word(0);
                        lhs = top_word(1);
                        if ((k == sme_pkg::OP_DIV || k == sme_pkg::OP_MOD) && rhs == 0)
                            r.status = sme_pkg::ST_DIVZ;
                        else begin
                            case (k)
                                sme_pkg::OP_ADD: res = lhs + rhs;
                                sme_pkg::OP_SUB: res = lhs - rhs;
                                sme_pkg::OP_MUL: res = lhs * rhs;
                                default: begin
                                    // most negative over minus one wraps
                                    if (lhs == 32'sh8000_0000 && rhs == -1)
                                        res = (k == sme_pkg::OP_DIV) ? 32'h8000_0000 : 32'h0;
                                    else
                                        res = (k == sme_pkg::OP_DIV) ? lhs / rhs : lhs % rhs;
                                end
                            endcase
                            depth--;
                            stk[depth-1] = res;
                        end
                    end
                end
                sme_pkg::OP_JMP: begin
                    r.branch_taken = 1'b1;
                    r.branch_label = imm;
                end
                sme_pkg::OP_JZ, sme_pkg::OP_JN: begin
                    if (depth < 1) r.status = sme_pkg::ST_UNDER;
                    else begin
                        res = top_word(0);
                        depth--;
                        if ((k == sme_pkg::OP_JZ && res == 0) ||
                            (k == sme_pkg::OP_JN && res[31])) begin
                            r.branch_taken = 1'b1;
                            r.branch_label = imm;
                        end
                    end
                end
                sme_pkg::OP_OUTCHAR: begin
                    if (depth < 1) r.status = sme_pkg::ST_UNDER;
                    else begin
                        res = top_word(0);
                        r.char_valid = 1'b1;
                        r.out_char = res[7:0];
                        depth--;
                    end
                end
                sme_pkg::OP_READCHAR: begin
                    if (depth < 1) r.status = sme_pkg::ST_UNDER;
                    else if (!addr_ok(top_word(0))) r.status = sme_pkg::ST_ADDR;
                    else begin
                        heap[top_word(0)] = {{23{ich[8]}}, ich};
                        heap_set[top_word(0)] = 1'b1;
                        depth--;
                    end
                end
                sme_pkg::OP_EXIT: exited = 1'b1;
                default: ;
            endcase
            r.halted = exited;
            pending.insert(pending.size(), r);
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_result(exec_result_t got);
            exec_result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp cv=%0b ch=%h bt=%0b bl=%h h=%0b st=%0d",
                              " got cv=%0b ch=%h bt=%0b bl=%h h=%0b st=%0d"},
                             want.char_valid, want.out_char, want.branch_taken,
                             want.branch_label, want.halted, want.status,
                             got.char_valid, got.out_char, got.branch_taken,
                             got.branch_label, got.halted, got.status);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [4:0]  s_kind = '0;
    logic [31:0] s_immediate = '0;
    logic [8:0]  s_input_char = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_char_valid;
    logic [7:0]  m_out_char;
    logic        m_branch_taken;
    logic [31:0] m_branch_label;
    logic        m_halted;
    logic [2:0]  m_status;

    sme_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int cycles = 0;

    stack_machine_execute i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_immediate(s_immediate), .s_input_char(s_input_char),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_char_valid(m_char_valid), .m_out_char(m_out_char),
        .m_branch_taken(m_branch_taken), .m_branch_label(m_branch_label),
        .m_halted(m_halted), .m_status(m_status)
    );

    always #2 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[stack_machine_execute] ERROR");
            $finish;
        end
    end

    // Check every result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_char_valid, m_out_char, m_branch_taken,
                             m_branch_label, m_halted, m_status});
    end

    // Result side: random stall bursts, one long hold on request
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Offer one beat, with an optional idle burst ahead of it
    task automatic send_beat(logic [4:0] k, logic [31:0] imm, logic [8:0] ich);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_kind = k;
        s_immediate = imm;
        s_input_char = ich;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(k, imm, ich);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return $urandom_range(0, 20);
        if (sel < 65) return $urandom_range(0, HEAP_N - 1);
        if (sel < 90) return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'hFFFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return HEAP_N;
            default: return -5;
        endcase
    endfunction

    // Draw one random instruction from the current machine state
    task automatic send_random();
        logic [4:0] k;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) k = sme_pkg::OP_PUSH;
        else if (sel < 35) k = sme_pkg::OP_DUP;
        else if (sel < 42) k = sme_pkg::OP_STORE;
        else if (sel < 48) k = sme_pkg::OP_RETRIEVE;
        else if (sel < 63) k = 5'($urandom_range(sme_pkg::OP_ADD, sme_pkg::OP_MOD));
        else if (sel < 67) k = sme_pkg::OP_JMP;
        else if (sel < 75) k = 5'($urandom_range(sme_pkg::OP_JZ, sme_pkg::OP_JN));
        else if (sel < 81) k = sme_pkg::OP_OUTCHAR;
        else if (sel < 88) k = sme_pkg::OP_READCHAR;
        else if (sel < 91) k = sme_pkg::OP_HALT;
        else if (sel < 94) k = 5'($urandom_range(18, 31));
        else k = $urandom_range(0, 1) ? sme_pkg::OP_POP : sme_pkg::OP_DISCARD;
        // never read a heap word that was never written
        if (k == sme_pkg::OP_RETRIEVE && sb.depth >= 1 && sb.addr_ok(sb.top_word(0))
                && !sb.heap_set[sb.top_word(0)])
            k = sme_pkg::OP_READCHAR;
        send_beat(k, (k == sme_pkg::OP_PUSH) ? pick_value() : $urandom,
                  9'($urandom_range(0, 511)));
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed opening
        send_beat(sme_pkg::OP_POP, 0, 0);                  // underflow on empty stack
        send_beat(sme_pkg::OP_OUTCHAR, 0, 0);
        send_beat(sme_pkg::OP_PUSH, 32'h7FFF_FFFF, 0);
        send_beat(sme_pkg::OP_PUSH, 1, 0);
        send_beat(sme_pkg::OP_ADD, 0, 0);                  // wraps to most negative
        send_beat(sme_pkg::OP_PUSH, 32'hFFFF_FFFF, 0);
        send_beat(sme_pkg::OP_DIV, 0, 0);                  // overflowing division
        send_beat(sme_pkg::OP_PUSH, 0, 0);
        send_beat(sme_pkg::OP_MOD, 0, 0);                  // divide by zero
        send_beat(sme_pkg::OP_PUSH, 4095, 0);
        send_beat(sme_pkg::OP_READCHAR, 0, 9'h1FF);        // end of input stored as -1
        send_beat(sme_pkg::OP_PUSH, 4095, 0);
        send_beat(sme_pkg::OP_RETRIEVE, 0, 0);
        send_beat(sme_pkg::OP_JN, 32'h8000_0000, 0);       // taken
        send_beat(sme_pkg::OP_PUSH, 32'h8000_0000, 0);
        send_beat(sme_pkg::OP_RETRIEVE, 0, 0);             // bad heap address
        send_beat(sme_pkg::OP_PUSH, 4096, 0);
        send_beat(sme_pkg::OP_STORE, 0, 0);                // bad heap address
        send_beat(sme_pkg::OP_JZ, 32'h7FFF_FFFF, 0);       // not taken, still pops
        send_beat(sme_pkg::OP_JMP, 32'h8000_0000, 0);
        send_beat(sme_pkg::OP_HALT, 0, 0);
        send_beat(5'd31, 0, 0);                            // unused opcode
        send_beat(sme_pkg::OP_PUSH, 32'h1234_5641, 0);
        send_beat(sme_pkg::OP_OUTCHAR, 0, 0);
        send_beat(sme_pkg::OP_DISCARD, 0, 0);

        repeat (380) send_random();

        // fill the stack to overflow, with the receiver held off meanwhile
        hold_req = 1'b1;
        while (sb.depth < STK_N) send_beat(sme_pkg::OP_PUSH, pick_value(), 0);
        send_beat(sme_pkg::OP_PUSH, 1, 0);
        send_beat(sme_pkg::OP_DUP, 0, 0);
        repeat (20) send_beat(sme_pkg::OP_MUL, 0, 0);

        repeat (360) send_random();

        quiet = 1'b1;
        repeat (20) send_random();
        send_beat(sme_pkg::OP_EXIT, 0, 0);
        repeat (5) send_random();
        s_valid = 1'b0;

        wait (sb.pending.size() == 0);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[stack_machine_execute] OK");
        else
            $display("[stack_machine_execute] ERROR");
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/sme_pkg.sv
hw/rtl/sme_div.sv
hw/rtl/sme_dp.sv
hw/rtl/sme_ctrl.sv
hw/rtl/stack_machine_execute.sv
dv/tb_stack_machine_execute.sv
